// ===== hw/rtl/mm2_pkg.sv =====
package mm2_pkg;

    localparam logic [31:0] HASH_MUL      = 32'h5BD1E995;
    localparam int          WORD_SHIFT    = 24;
    localparam int          FINAL_SHIFT_A = 13;
    localparam int          FINAL_SHIFT_B = 15;
    localparam int          QUEUE_DEPTH   = 2;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_NONE = 2'd0;
    localparam kind_t KIND_TAIL = 2'd1;
    localparam kind_t KIND_FULL = 2'd2;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] word;
        logic        first;
        logic        last;
        logic [31:0] length;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== hw/rtl/mm2_in_if.sv =====
interface mm2_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  bytes_valid;
    logic        first_word;
    logic        last_word;
    logic [31:0] total_length;

    modport source (output valid, data_word, bytes_valid, first_word, last_word, total_length,
                    input ready);
    modport sink (input valid, data_word, bytes_valid, first_word, last_word, total_length,
                  output ready);
endinterface

// ===== hw/rtl/mm2_out_if.sv =====
interface mm2_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest;

    modport source (output valid, digest, input ready);
    modport sink (input valid, digest, output ready);
endinterface

// ===== hw/rtl/murmur2_hash32_core.sv =====
// 32-bit MurmurHash2 (seed 0) over a stream of little-endian words. The front
// end classifies each beat (full word, partial word, no bytes) and writes it to
// a small queue; the back end mixes items one at a time through a single
// 32x32 multiplier by 0x5BD1E995, which sets the rate: a full word takes two
// multiplies of k and one of the running hash h, a partial word only that of
// h, an empty word none; a last word adds the final avalanche, which loads
// the hash into the output register. The first word loads h with total_length;
// the hash beat follows every last word, and h then returns to zero.
module murmur2_hash32_core
    import mm2_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    mm2_in_if.sink    msg,
    mm2_out_if.source hash
);

    q_stat_t q_stat;
    logic    push;
    logic    pop;
    item_t   push_item;
    item_t   pop_item;

    mm2_front u_front (
        .msg    (msg),
        .q_stat (q_stat),
        .push   (push),
        .item   (push_item)
    );

    mm2_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .stat      (q_stat)
    );

    mm2_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .item   (pop_item),
        .pop    (pop),
        .hash   (hash)
    );

`ifndef NO_ASSERTIONS
    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !msg.ready)
        else $error("input accepted while queue full");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("back end popped an empty queue");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        msg.valid && msg.ready && q_stat.empty |=> !q_stat.empty)
        else $error("accepted beat did not reach the queue");
`endif

endmodule

// ===== hw/rtl/mm2_front.sv =====
module mm2_front
    import mm2_pkg::*;
(
    mm2_in_if.sink  msg,
    input  q_stat_t q_stat,
    output logic    push,
    output item_t   item
);

    assign msg.ready = !q_stat.full;
    assign push      = msg.valid && msg.ready;

    always_comb
    begin
        item.first  = msg.first_word;
        item.last   = msg.last_word;
        item.length = msg.total_length;
        item.word   = msg.data_word;
        item.kind   = KIND_FULL;
        case (msg.bytes_valid) inside
            3'd0:
            begin
                item.kind = KIND_NONE;
            end
            [3'd1:3'd3]:
            begin
                item.kind = KIND_TAIL;
                // drop the bytes above the valid count
                case (msg.bytes_valid)
                    3'd1:    item.word = {24'd0, msg.data_word[7:0]};
                    3'd2:    item.word = {16'd0, msg.data_word[15:0]};
                    default: item.word = {8'd0, msg.data_word[23:0]};
                endcase
            end
            default:
            begin
                item.kind = KIND_FULL;
            end
        endcase
    end

endmodule

// ===== hw/rtl/mm2_queue.sv =====
module mm2_queue
    import mm2_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  item_t   push_item,
    input  logic    pop,
    output item_t   pop_item,
    output q_stat_t stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t          mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_item   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/mm2_back.sv =====
module mm2_back
    import mm2_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_stat_t    q_stat,
    input  item_t      item,
    output logic       pop,
    mm2_out_if.source  hash
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_K1   = 3'd1;
    localparam logic [2:0] ST_K2   = 3'd2;
    localparam logic [2:0] ST_H    = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] k_reg, k_next;
    logic        last_reg, last_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_hash_reg, out_hash_next;

    logic [31:0] base;
    logic [31:0] mul_a;
    logic [31:0] product;
    logic        out_load;

    assign base       = item.first ? item.length : h_reg;
    assign pop        = (state_reg == ST_IDLE) && !q_stat.empty;
    assign out_load   = (state_reg == ST_FIN) && (!out_valid_reg || hash.ready);
    assign hash.valid  = out_valid_reg;
    assign hash.digest = out_hash_reg;

    // one shared multiplier by the hash constant
    always_comb
    begin
        case (state_reg)
            ST_K1:   mul_a = k_reg;
            ST_K2:   mul_a = k_reg ^ (k_reg >> WORD_SHIFT);
            ST_H:    mul_a = h_reg;
            ST_FIN:  mul_a = h_reg ^ (h_reg >> FINAL_SHIFT_A);
            default: mul_a = k_reg;
        endcase
    end

    assign product = mul_a * HASH_MUL;

    always_comb
    begin
        state_next    = state_reg;
        h_next        = h_reg;
        k_next        = k_reg;
        last_next     = last_reg;
        out_hash_next = out_hash_reg;
        out_valid_next = out_valid_reg && !hash.ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    last_next = item.last;
                    case (item.kind)
                        KIND_FULL:
                        begin
                            h_next     = base;
                            k_next     = item.word;
                            state_next = ST_K1;
                        end
                        KIND_TAIL:
                        begin
                            h_next     = base ^ item.word;
                            k_next     = '0;
                            state_next = ST_H;
                        end
                        default:
                        begin
                            h_next     = base;
                            state_next = item.last ? ST_FIN : ST_IDLE;
                        end
                    endcase
                end
            end
            ST_K1:
            begin
                k_next     = product;
                state_next = ST_K2;
            end
            ST_K2:
            begin
                k_next     = product;
                state_next = ST_H;
            end
            ST_H:
            begin
                h_next     = product ^ k_reg;
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                // hold until the output register is free
                if (out_load)
                begin
                    out_hash_next  = product ^ (product >> FINAL_SHIFT_B);
                    out_valid_next = 1'b1;
                    h_next         = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            h_reg         <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        out_hash_reg <= out_hash_next;
    end

endmodule
